/* sv/aea_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aea_pkg
// Shared widths, defaults, register indexes and types for the echo adder.
// ----------------------------------------------------------------------------
package aea_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int DELAY_W         = 14;
    localparam int DIVISOR_W       = 16;
    localparam int DELAY_MAX       = 8192;
    localparam int PTR_W           = $clog2(DELAY_MAX);
    localparam int DEFAULT_DELAY   = 8000;
    localparam int DEFAULT_DIVISOR = 4;
    // zero delay falls back to the default, itself limited to the ring size
    localparam int ZERO_DELAY      = (DEFAULT_DELAY > DELAY_MAX) ? DELAY_MAX : DEFAULT_DELAY;
    localparam int DIV_CNT_W       = $clog2(SAMPLE_W);

    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [DELAY_W-1:0]         t_delay;
    typedef logic [DIVISOR_W-1:0]       t_divisor;
    typedef logic [PTR_W-1:0]           t_ptr;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]      t_cfg_data;

    localparam t_cfg_idx REG_DELAY   = t_cfg_idx'(0);
    localparam t_cfg_idx REG_DIVISOR = t_cfg_idx'(1);

endpackage
`default_nettype wire

/* sv/aea_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aea_if
// Valid/ready channels of the echo adder: sample in, sample out, config write.
// ----------------------------------------------------------------------------
interface aea_in_if;
    logic             valid;
    logic             ready;
    aea_pkg::t_sample in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

interface aea_out_if;
    logic             valid;
    logic             ready;
    aea_pkg::t_sample out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

interface aea_cfg_if;
    logic               valid;
    logic               ready;
    aea_pkg::t_cfg_idx  index;
    aea_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/aea_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aea_div
// Radix-2 restoring divider: signed sample by unsigned divisor, quotient
// truncated toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module aea_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire aea_pkg::t_sample  i_dividend,
    input  wire aea_pkg::t_divisor i_divisor,
    output logic                   o_done,
    output aea_pkg::t_sample       o_quotient
);

    localparam int W = aea_pkg::SAMPLE_W;

    logic                            r_busy;
    logic                            r_done;
    logic [aea_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic                            r_neg;
    aea_pkg::t_divisor               r_div;
    logic [aea_pkg::DIVISOR_W-1:0]   r_rem;
    logic [W-1:0]                    r_quo;

    logic [W-1:0]                    w_dvd_u;
    logic [W-1:0]                    w_mag;
    logic [aea_pkg::DIVISOR_W:0]     w_shift;
    logic [aea_pkg::DIVISOR_W:0]     w_diff;

    assign w_dvd_u = i_dividend;
    // magnitude of the most negative sample still fits as unsigned
    assign w_mag   = w_dvd_u[W-1] ? (~w_dvd_u + 1'b1) : w_dvd_u;
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
                r_neg  <= w_dvd_u[W-1];
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= w_mag;
            end else if (r_busy) begin
                if (!w_diff[aea_pkg::DIVISOR_W]) begin
                    r_rem <= w_diff[aea_pkg::DIVISOR_W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[aea_pkg::DIVISOR_W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? aea_pkg::t_sample'(~r_quo + 1'b1) : aea_pkg::t_sample'(r_quo);

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && !r_done))
        else $error("divider did not begin after start");
`endif

endmodule
`default_nettype wire

/* sv/audio_echo_adder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// audio_echo_adder
// Adds a delayed, divided echo to a stream of signed 16-bit PCM samples.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. An input transfer starts the radix-2
// divider that scales each sample for the echo ring; its quotient is then
// handed over and the result is registered in the output register. The next
// input is taken once the result is produced. A sample is held back when the
// previous result is still held in the output register by the sink.
// The echo ring is an 8192 x 16 single-port-style RAM. It is read at input
// transfer and written when the result is produced. For the first
// delay_samples inputs after reset or after a delay or divisor write, the output
// equals the input. Such a write also restarts that count and the ring
// pointer. Delay 0 acts as 8000 and divisor 0 acts as 4. Write configuration
// only while no sample is pending.
// ----------------------------------------------------------------------------
module audio_echo_adder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    aea_in_if.sink    i_in,
    aea_out_if.source o_out,
    aea_cfg_if.sink   i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    t_state             r_state;
    aea_pkg::t_delay    r_delay;
    aea_pkg::t_divisor  r_divisor;
    aea_pkg::t_ptr      r_ptr;
    aea_pkg::t_delay    r_fill;
    aea_pkg::t_ptr      r_cur_ptr;
    aea_pkg::t_sample   r_sample;
    logic               r_pass;
    logic               r_out_valid;
    aea_pkg::t_sample   r_out;
    aea_pkg::t_sample   r_rd;

    aea_pkg::t_sample   r_ring [aea_pkg::DELAY_MAX];

    aea_pkg::t_delay    w_act_delay;
    aea_pkg::t_divisor  w_act_div;
    aea_pkg::t_ptr      w_ptr_eff;
    aea_pkg::t_delay    w_ptr_inc;
    aea_pkg::t_ptr      w_ptr_next;
    logic               w_in_xfer;
    logic               w_out_xfer;
    logic               w_cfg_xfer;
    logic               w_finish;
    logic               w_div_done;
    aea_pkg::t_sample   w_quot;

    assign w_act_delay = (r_delay == '0) ? aea_pkg::t_delay'(aea_pkg::ZERO_DELAY) :
                         (r_delay > aea_pkg::t_delay'(aea_pkg::DELAY_MAX)) ?
                             aea_pkg::t_delay'(aea_pkg::DELAY_MAX) : r_delay;
    assign w_act_div   = (r_divisor == '0) ?
                             aea_pkg::t_divisor'(aea_pkg::DEFAULT_DIVISOR) : r_divisor;

    assign w_ptr_eff  = ({1'b0, r_ptr} >= w_act_delay) ? '0 : r_ptr;
    assign w_ptr_inc  = {1'b0, r_cur_ptr} + 1'b1;
    assign w_ptr_next = (w_ptr_inc >= w_act_delay) ? '0 : w_ptr_inc[aea_pkg::PTR_W-1:0];

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_out.valid && o_out.ready;
    assign w_cfg_xfer = i_cfg.valid && i_cfg.ready;
    assign w_finish   = ((r_state == S_DIV && w_div_done) || r_state == S_FIN) &&
                        (!r_out_valid || o_out.ready);

    aea_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_xfer),
        .i_dividend (i_in.in_sample),
        .i_divisor  (w_act_div),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // echo ring: read on input transfer, written back when the result is produced
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_ring[r_cur_ptr] <= w_quot;
        end
        if (w_in_xfer) begin
            r_rd <= r_ring[w_ptr_eff];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_delay     <= aea_pkg::t_delay'(aea_pkg::DEFAULT_DELAY);
            r_divisor   <= aea_pkg::t_divisor'(aea_pkg::DEFAULT_DIVISOR);
            r_ptr       <= '0;
            r_fill      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_sample  <= i_in.in_sample;
                        r_cur_ptr <= w_ptr_eff;
                        r_pass    <= (r_fill < w_act_delay);
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_finish) begin
                        r_state <= S_IDLE;
                    end else if (w_div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_finish) begin
                r_out_valid <= 1'b1;
                r_out       <= r_pass ? r_sample : aea_pkg::t_sample'(r_rd + r_sample);
                r_ptr       <= w_ptr_next;
                if (r_pass) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end

            if (w_cfg_xfer) begin
                unique case (i_cfg.index)
                    aea_pkg::REG_DELAY: begin
                        r_delay <= i_cfg.data[aea_pkg::DELAY_W-1:0];
                        r_ptr   <= '0;
                        r_fill  <= '0;
                    end
                    aea_pkg::REG_DIVISOR: begin
                        r_divisor <= i_cfg.data[aea_pkg::DIVISOR_W-1:0];
                        r_ptr     <= '0;
                        r_fill    <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.out_sample = r_out;
    assign i_cfg.ready      = 1'b1;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_act_delay)
        else $error("fill count beyond active delay");
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_ptr} < w_act_delay)
        else $error("ring pointer beyond active delay");
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (r_state == S_IDLE && o_out.valid))
        else $error("result not presented after finish");
`endif

endmodule
`default_nettype wire
